/* rtl/lrupr_pkg.sv */
`timescale 1ns / 1ps
// Package for the LRU page replacement block: table sizes, widths, the
// sequencer state type and the structs passed between the top level and the table.
package lrupr_pkg;

  localparam int FRAMES    = 8;
  localparam int PAGE_BITS = 16;
  localparam int FRAME_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W     = $clog2(FRAMES + 1);
  localparam int CFG_W     = 4;
  localparam int FAULT_W   = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } lrupr_state_t;

  typedef struct packed {
    logic                 valid;
    logic [FRAME_W-1:0]   rank;
    logic [PAGE_BITS-1:0] page;
  } lrupr_rd_t;

  typedef struct packed {
    logic                 en;
    logic                 wr_page;
    logic                 clear;
    logic [FRAME_W-1:0]   frame;
    logic [PAGE_BITS-1:0] page;
    logic [CNT_W-1:0]     old_rank;
  } lrupr_upd_t;

endpackage

/* rtl/lrupr_table.sv */
`timescale 1ns / 1ps
// Frame table: page numbers, valid bits and recency ranks, one read port.
// Depends on lrupr_pkg for sizes and the read and update structs.
module lrupr_table (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [lrupr_pkg::FRAME_W-1:0] rd_addr,
  output lrupr_pkg::lrupr_rd_t         rd,
  output logic [lrupr_pkg::CNT_W-1:0]  valid_count,
  input  lrupr_pkg::lrupr_upd_t        upd
);
  import lrupr_pkg::*;

  logic [PAGE_BITS-1:0] frame_page [FRAMES];
  logic [FRAMES-1:0]    frame_valid;
  logic [FRAME_W-1:0]   recency_rank [FRAMES];

  always_ff @(posedge clk) begin
    if (upd.en && upd.wr_page) begin
      frame_page[upd.frame] <= upd.page;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        recency_rank[i] <= '0;
      end
    end else if (upd.en) begin
      if (upd.clear) begin
        frame_valid <= '0;
        for (int i = 0; i < FRAMES; i++) begin
          recency_rank[i] <= '0;
        end
      end else begin
        for (int i = 0; i < FRAMES; i++) begin
          if (FRAME_W'(i) == upd.frame) begin
            frame_valid[i]  <= 1'b1;
            recency_rank[i] <= '0;
          end else if (frame_valid[i] && (CNT_W'(recency_rank[i]) < upd.old_rank)) begin
            recency_rank[i] <= recency_rank[i] + 1'b1;
          end
        end
      end
    end
  end

  assign rd.valid    = frame_valid[rd_addr];
  assign rd.rank     = recency_rank[rd_addr];
  assign rd.page     = frame_page[rd_addr];
  assign valid_count = CNT_W'($countones(frame_valid));

endmodule

/* rtl/lru_page_replacement_top.sv */
`timescale 1ns / 1ps
// Top level of the LRU page replacement block: sequencer, fault counter and
// result register. Depends on lrupr_pkg and lrupr_table.
//
// Channel | Direction | Handshake            | Word
// in      | input     | in_valid / in_stall  | page_number, last_in_sequence
// out     | output    | out_valid / out_stall| page_fault, frame_index, fault_count, sequence_end
// cfg     | input     | cfg_we               | cfg_wdata (frames in use)
//
// A reference passes through an accept state, a scan state that compares one
// active frame at a time (stopping early at the first hit) and an update state.
// The update cycle waits while the result register is full and stalled.
// Reset is synchronous; it empties the table, zeroes the fault count and
// sets the frames in use to eight.
module lru_page_replacement_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [lrupr_pkg::PAGE_BITS-1:0] page_number,
  input  logic                           last_in_sequence,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           page_fault,
  output logic [2:0]                     frame_index,
  output logic [lrupr_pkg::FAULT_W-1:0]  fault_count,
  output logic                           sequence_end,
  input  logic                           cfg_we,
  input  logic [lrupr_pkg::CFG_W-1:0]    cfg_wdata
);
  import lrupr_pkg::*;

  lrupr_state_t         state;
  lrupr_state_t         state_next;
  logic [CFG_W-1:0]     frames_in_use;
  logic [CNT_W-1:0]     n_act;
  logic [FRAME_W-1:0]   idx;
  logic [PAGE_BITS-1:0] page_r;
  logic                 last_r;
  logic                 hit_found;
  logic [FRAME_W-1:0]   hit_idx;
  logic                 empty_found;
  logic [FRAME_W-1:0]   empty_idx;
  logic [FRAME_W-1:0]   worst_rank;
  logic [FRAME_W-1:0]   worst_idx;
  logic [FAULT_W-1:0]   faults_seen;
  logic [FAULT_W-1:0]   faults_next;
  logic [FRAME_W-1:0]   sel_frame;
  logic [FRAME_W-1:0]   rd_addr;
  logic                 in_accept;
  logic                 upd_fire;
  logic                 hit_now;
  logic                 scan_last;
  logic [CNT_W-1:0]     valid_count;
  lrupr_rd_t            rd;
  lrupr_upd_t           upd;

  lrupr_table u_table (
    .clk         (clk),
    .rst         (rst),
    .rd_addr     (rd_addr),
    .rd          (rd),
    .valid_count (valid_count),
    .upd         (upd)
  );

  always_comb begin
    if (frames_in_use == '0) begin
      n_act = CNT_W'(1);
    end else if (frames_in_use > CFG_W'(FRAMES)) begin
      n_act = CNT_W'(FRAMES);
    end else begin
      n_act = CNT_W'(frames_in_use);
    end
  end

  assign in_accept = in_valid && !in_stall;
  assign hit_now   = rd.valid && (rd.page == page_r);
  assign scan_last = (CNT_W'(idx) == (n_act - CNT_W'(1)));

  always_comb begin
    if (hit_found) begin
      sel_frame = hit_idx;
    end else if (empty_found) begin
      sel_frame = empty_idx;
    end else begin
      sel_frame = worst_idx;
    end
  end

  assign faults_next = (!hit_found && (faults_seen != '1)) ? faults_seen + 1'b1 : faults_seen;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit_now || scan_last) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    upd_fire = 1'b0;
    rd_addr  = idx;
    case (state)
      ST_IDLE: begin
        in_stall = rst;
      end
      ST_SCAN: begin
        rd_addr = idx;
      end
      ST_UPDATE: begin
        rd_addr  = sel_frame;
        upd_fire = !out_valid || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    upd.en       = upd_fire;
    upd.wr_page  = !hit_found;
    upd.clear    = last_r;
    upd.frame    = sel_frame;
    upd.page     = page_r;
    upd.old_rank = rd.valid ? CNT_W'(rd.rank) : valid_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      frames_in_use <= CFG_W'(8);
      faults_seen   <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        frames_in_use <= cfg_wdata;
      end
      if (upd_fire) begin
        faults_seen <= last_r ? '0 : faults_next;
        out_valid   <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      idx         <= '0;
      page_r      <= page_number;
      last_r      <= last_in_sequence;
      hit_found   <= 1'b0;
      empty_found <= 1'b0;
    end else if (state == ST_SCAN) begin
      idx <= idx + 1'b1;
      if (!hit_found && hit_now) begin
        hit_found <= 1'b1;
        hit_idx   <= idx;
      end
      if (!empty_found && !rd.valid) begin
        empty_found <= 1'b1;
        empty_idx   <= idx;
      end
      if ((idx == '0) || (rd.rank > worst_rank)) begin
        worst_rank <= rd.rank;
        worst_idx  <= idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      page_fault   <= !hit_found;
      frame_index  <= 3'(sel_frame);
      fault_count  <= faults_next;
      sequence_end <= last_r;
    end
  end

`ifndef NO_ASSERTIONS
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (CNT_W'(idx) < n_act))
    else $error("scan index beyond frames in use");

  a_result_from_update: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_UPDATE))
    else $error("result appeared without an update cycle");

  a_fault_counted: assert property (@(posedge clk) disable iff (rst)
    (out_valid && page_fault) |-> (fault_count != '0))
    else $error("fault reported with zero fault count");

  a_victim_full: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_UPDATE) && !hit_found && !empty_found) |-> (valid_count >= n_act))
    else $error("replacement chosen while an active frame is empty");
`endif

endmodule
